[rtl/ppt_pkg.sv]
// ----------------------------------------------------------------------------
// ppt_pkg
// shared widths, defaults and types for the point-in-polygon test block
// ----------------------------------------------------------------------------
package ppt_pkg;

    // default vertex capacity
    localparam int DEF_MAX_VERTICES = 64;

    // coordinate, difference and product widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // controls from the walk sequencer to the edge tester
    typedef struct packed {
        logic clear;   // new query: reset parity
        logic valid;   // an edge is presented this cycle
    } ppt_edge_ctrl_t;

endpackage

[rtl/ppt_cell.sv]
// ----------------------------------------------------------------------------
// ppt_cell
// one vertex slot of the rotating vertex chain
// ----------------------------------------------------------------------------
module ppt_cell (
    input  logic                                clk,
    input  logic                                shift_en,
    input  logic                                wr_en,
    input  logic signed [ppt_pkg::COORD_W-1:0]  shift_x,
    input  logic signed [ppt_pkg::COORD_W-1:0]  shift_y,
    input  logic signed [ppt_pkg::COORD_W-1:0]  wr_x,
    input  logic signed [ppt_pkg::COORD_W-1:0]  wr_y,
    output logic signed [ppt_pkg::COORD_W-1:0]  x,
    output logic signed [ppt_pkg::COORD_W-1:0]  y
);

    logic signed [ppt_pkg::COORD_W-1:0] x_reg;
    logic signed [ppt_pkg::COORD_W-1:0] y_reg;

    // write has priority; the sequencer never does both at once
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
        else if (shift_en)
        begin
            x_reg <= shift_x;
            y_reg <= shift_y;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

[rtl/ppt_edge.sv]
// ----------------------------------------------------------------------------
// ppt_edge
// pipelined exact crossing test of one edge per cycle with parity accumulator
// ----------------------------------------------------------------------------
module ppt_edge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppt_pkg::ppt_edge_ctrl_t             ctrl,
    input  logic signed [ppt_pkg::COORD_W-1:0]  px,
    input  logic signed [ppt_pkg::COORD_W-1:0]  py,
    input  logic signed [ppt_pkg::COORD_W-1:0]  xi,
    input  logic signed [ppt_pkg::COORD_W-1:0]  yi,
    input  logic signed [ppt_pkg::COORD_W-1:0]  xj,
    input  logic signed [ppt_pkg::COORD_W-1:0]  yj,
    output logic                                parity
);

    localparam int DW = ppt_pkg::DIFF_W;
    localparam int PW = ppt_pkg::PROD_W;

    logic signed [DW-1:0] d_pxi;   // px - xi
    logic signed [DW-1:0] d_dy;    // yj - yi
    logic signed [DW-1:0] d_xe;    // xj - xi
    logic signed [DW-1:0] d_pyi;   // py - yi
    logic                 straddle;

    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [DW-1:0] a_next, b_next, c_next, d_next;
    logic                 s1_valid_reg;
    logic                 s1_strad_reg;

    logic signed [PW-1:0] p1_reg, p2_reg;
    logic                 s2_valid_reg;
    logic                 s2_strad_reg;

    logic                 parity_reg;
    logic                 parity_next;

    always_comb
    begin
        d_pxi    = DW'(px) - DW'(xi);
        d_dy     = DW'(yj) - DW'(yi);
        d_xe     = DW'(xj) - DW'(xi);
        d_pyi    = DW'(py) - DW'(yi);
        straddle = (yi > py) != (yj > py);
        // orient so the test is p1 < p2 with a positive denominator
        if (d_dy > 0)
        begin
            a_next = d_pxi;
            b_next = d_dy;
            c_next = d_xe;
            d_next = d_pyi;
        end
        else
        begin
            a_next = d_xe;
            b_next = d_pyi;
            c_next = d_pxi;
            d_next = d_dy;
        end
    end

    // operand stage
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        s1_strad_reg <= straddle;
    end

    // product stage
    always_ff @(posedge clk)
    begin
        p1_reg       <= a_reg * b_reg;
        p2_reg       <= c_reg * d_reg;
        s2_strad_reg <= s1_strad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_comb
    begin
        parity_next = parity_reg;
        if (ctrl.clear)
            parity_next = 1'b0;
        else if (s2_valid_reg && s2_strad_reg && (p1_reg < p2_reg))
            parity_next = ~parity_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            parity_reg <= 1'b0;
        else
            parity_reg <= parity_next;
    end

    assign parity = parity_reg;

endmodule

[rtl/point_in_polygon_test_top.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// crossing-number point-in-polygon test over a rotating chain of vertex cells
// ----------------------------------------------------------------------------
// The polygon lives in a chain of MAX_VERTICES cells, one vertex per cell.
// A vertex transfer (tuser[0] = 0) appends a vertex; with tuser[1] set it
// first restarts the polygon. Vertices past capacity are dropped and flagged
// until the next restart. A query transfer (tuser[0] = 1) rotates the chain
// once past the head cell, feeding one edge per cycle into a three-stage
// exact crossing tester (differences, 33x33 products, compare); the single
// edge tester sits at the head of the chain. Inputs are taken only between
// queries; a finished result sits in the output register while the next item
// is accepted. Empty polygons answer outside.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = ppt_pkg::DEF_MAX_VERTICES
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] coord_x, [63:32] coord_y
    input  logic [1:0]  s_tuser,    // [0] req_type, [1] first_vertex
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [0] inside_res, [1] vertices_dropped, rest zero
);

    localparam int CW     = ppt_pkg::COORD_W;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int STEP_W = $clog2(MAX_VERTICES + 4);
    // end of the rotation, and the step at which the tester pipeline has drained
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_VERTICES);
    localparam logic [STEP_W-1:0] DONE_STEP = STEP_W'(MAX_VERTICES + 3);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // sequencer state
    logic              state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [1:0]        res_reg, res_next;

    // query point and walk registers (payload)
    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] v0x_reg, v0y_reg;
    logic signed [CW-1:0] prevx_reg, prevy_reg;

    // input field views
    logic                 in_req;
    logic                 in_first;
    logic signed [CW-1:0] in_x, in_y;
    logic                 in_acc;

    // vertex chain
    logic signed [CW-1:0] cell_x [MAX_VERTICES];
    logic signed [CW-1:0] cell_y [MAX_VERTICES];
    logic                 rotate;
    logic                 vtx_wr;
    logic [CNT_W-1:0]     wr_idx;

    // walk datapath
    logic signed [CW-1:0]    cur_x, cur_y;
    logic [STEP_W-1:0]       n_ext;
    ppt_pkg::ppt_edge_ctrl_t edge_ctrl;
    logic                    parity;

    assign in_req   = s_tuser[0];
    assign in_first = s_tuser[1];
    assign in_x     = s_tdata[CW-1:0];
    assign in_y     = s_tdata[2*CW-1:CW];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // append target: slot zero on a restart, else the next free slot
    assign wr_idx = in_first ? '0 : count_reg;
    assign vtx_wr = in_acc && (in_req == REQ_VERTEX)
                  && (in_first || (count_reg < CNT_W'(MAX_VERTICES)));

    // full rotation over steps 0 .. MAX_VERTICES-1 restores the vertex order
    assign rotate = (state_reg == ST_WALK) && (step_reg < LAST_STEP);

    genvar k;
    generate
        for (k = 0; k < MAX_VERTICES; k++)
        begin : g_cell
            ppt_cell u_cell (
                .clk      (clk),
                .shift_en (rotate),
                .wr_en    (vtx_wr && (wr_idx == CNT_W'(k))),
                .shift_x  (cell_x[(k + 1) % MAX_VERTICES]),
                .shift_y  (cell_y[(k + 1) % MAX_VERTICES]),
                .wr_x     (in_x),
                .wr_y     (in_y),
                .x        (cell_x[k]),
                .y        (cell_y[k])
            );
        end
    endgenerate

    // at step t the head holds vertex t; step n closes the ring with vertex 0
    assign n_ext = STEP_W'(count_reg);
    always_comb
    begin
        if (step_reg == n_ext)
        begin
            cur_x = v0x_reg;
            cur_y = v0y_reg;
        end
        else
        begin
            cur_x = cell_x[0];
            cur_y = cell_y[0];
        end
    end

    always_comb
    begin
        edge_ctrl.clear = in_acc && (in_req == REQ_QUERY);
        edge_ctrl.valid = (state_reg == ST_WALK) && (step_reg != '0)
                        && (step_reg <= n_ext);
    end

    ppt_edge u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (edge_ctrl),
        .px     (px_reg),
        .py     (py_reg),
        .xi     (cur_x),
        .yi     (cur_y),
        .xj     (prevx_reg),
        .yj     (prevy_reg),
        .parity (parity)
    );

    // walk payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && (in_req == REQ_QUERY))
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (state_reg == ST_WALK)
        begin
            prevx_reg <= cur_x;
            prevy_reg <= cur_y;
            if (step_reg == '0)
            begin
                v0x_reg <= cell_x[0];
                v0y_reg <= cell_y[0];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_req == REQ_QUERY)
                    begin
                        state_next = ST_WALK;
                        step_next  = '0;
                    end
                    else
                    begin
                        if (in_first)
                        begin
                            count_next = CNT_W'(1);
                            ovf_next   = 1'b0;
                        end
                        else if (count_reg < CNT_W'(MAX_VERTICES))
                            count_next = count_reg + CNT_W'(1);
                        else
                            ovf_next = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                if (step_reg != DONE_STEP)
                    step_next = step_reg + STEP_W'(1);
                else if (!m_tvalid_reg || m_tready)
                begin
                    // result slot free: publish and go back to idle
                    m_tvalid_next = 1'b1;
                    res_next      = {ovf_reg, parity};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, res_reg};

endmodule

[bench/ppt_bench_pkg.sv]
// ----------------------------------------------------------------------------
// ppt_bench_pkg
// request codes and stream bit positions shared by the bench modules
// ----------------------------------------------------------------------------
package ppt_bench_pkg;

    // kind of input transfer, carried in tuser
    typedef enum logic {
        REQ_VERTEX = 1'b0,
        REQ_QUERY  = 1'b1
    } ppt_req_e;

    // tuser bit positions
    localparam int TUSER_REQ   = 0;
    localparam int TUSER_FIRST = 1;

    // result tdata bit positions
    localparam int RES_INSIDE  = 0;
    localparam int RES_DROPPED = 1;

endpackage

[bench/ppt_checker.sv]
// ----------------------------------------------------------------------------
// ppt_checker
// watches both streams, predicts each query answer and compares results
// ----------------------------------------------------------------------------
// Keeps a shadow polygon built from the accepted vertex transfers and runs an
// exact even-odd crossing count for every accepted query. Answers are queued
// in order and checked field by field against the result transfers.
// ----------------------------------------------------------------------------
module ppt_checker
    import ppt_pkg::*;
    import ppt_bench_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          fail_count,
    output int          pending,
    output int          answers,
    output int          answers_inside,
    output int          answers_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic in_poly;
        logic dropped;
    } ppt_answer_t;

    logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
    int unsigned               poly_len;
    logic                      poly_overflow;
    ppt_answer_t               answer_q [$];

    // exact test: edge straddles py and its crossing lies strictly right of px
    function automatic logic edge_crosses(
        logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
        logic signed [COORD_W-1:0] xi, logic signed [COORD_W-1:0] yi,
        logic signed [COORD_W-1:0] xj, logic signed [COORD_W-1:0] yj
    );
        logic signed [65:0] dx_pt, dx_edge, dy_pt, dy_edge;
        logic signed [65:0] lhs, rhs;
        if ((yi > py) == (yj > py))
            return 1'b0;
        dx_pt   = px;
        dx_pt   = dx_pt - xi;
        dx_edge = xj;
        dx_edge = dx_edge - xi;
        dy_pt   = py;
        dy_pt   = dy_pt - yi;
        dy_edge = yj;
        dy_edge = dy_edge - yi;
        // px - xi < dx_edge * dy_pt / dy_edge, with the divide moved across
        lhs = dx_pt * dy_edge;
        rhs = dx_edge * dy_pt;
        if (dy_edge > 0)
            return lhs < rhs;
        return rhs < lhs;
    endfunction

    // even-odd parity over all edges, vertex 0 paired with the last one
    function automatic logic polygon_parity(
        logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py
    );
        logic        parity;
        int unsigned prev;
        parity = 1'b0;
        prev   = poly_len - 1;
        for (int unsigned k = 0; k < poly_len; k++)
        begin
            if (edge_crosses(px, py, poly_x[k], poly_y[k], poly_x[prev], poly_y[prev]))
                parity = ~parity;
            prev = k;
        end
        return parity;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ppt_answer_t want;
        if (!rst_n)
        begin
            poly_len        = 0;
            poly_overflow   = 1'b0;
            answer_q.delete();
            fail_count      = 0;
            pending         = 0;
            answers         = 0;
            answers_inside  = 0;
            answers_dropped = 0;
        end
        else
        begin
            // results first: a query never answers in its own cycle
            if (m_tvalid && m_tready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result transfer with no query waiting, tdata=%h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    answers++;
                    if (m_tdata[RES_INSIDE])
                        answers_inside++;
                    if (m_tdata[RES_DROPPED])
                        answers_dropped++;
                    if (m_tdata[RES_INSIDE] !== want.in_poly)
                    begin
                        $error("inside_res: expected %0d, actual %0b",
                               want.in_poly, m_tdata[RES_INSIDE]);
                        fail_count++;
                    end
                    if (m_tdata[RES_DROPPED] !== want.dropped)
                    begin
                        $error("vertices_dropped: expected %0d, actual %0b",
                               want.dropped, m_tdata[RES_DROPPED]);
                        fail_count++;
                    end
                    if (m_tdata[7:2] !== 6'd0)
                    begin
                        $error("tdata padding: expected 0, actual %b", m_tdata[7:2]);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (ppt_req_e'(s_tuser[TUSER_REQ]) == REQ_VERTEX)
                begin
                    if (s_tuser[TUSER_FIRST])
                    begin
                        poly_len      = 0;
                        poly_overflow = 1'b0;
                    end
                    if (poly_len < MAX_VERTICES)
                    begin
                        poly_x[poly_len] = s_tdata[31:0];
                        poly_y[poly_len] = s_tdata[63:32];
                        poly_len++;
                    end
                    else
                        poly_overflow = 1'b1;
                end
                else
                begin
                    want.in_poly = polygon_parity(s_tdata[31:0], s_tdata[63:32]);
                    want.dropped = poly_overflow;
                    answer_q.push_back(want);
                end
            end
            pending = answer_q.size();
        end
    end

endmodule

[bench/tb_point_in_polygon_test_top.sv]
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test_top
// stimulus and verdict for the point-in-polygon test block
// ----------------------------------------------------------------------------
// Builds polygons from vertex transfers and fires query transfers at them: a
// short directed set (empty, one and two vertex polygons, a square spanning
// the whole coordinate range, ties on vertices and edges) and then random
// polygons of mixed scale, some past capacity, with noise between them. Both
// stream sides idle at random in two of three phases. The checker predicts and
// compares; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;
    import ppt_bench_pkg::*;

    localparam int MAX_V          = DEF_MAX_VERTICES;
    localparam int ITEMS_PER_PASS = 670;
    localparam int CYCLE_LIMIT    = 1_000_000;
    // settle time after the last pass, padded beyond the length of a query walk
    localparam int SETTLE_CYCLES  = MAX_V + 16;

    // coordinate ranges used by the generator
    typedef enum logic [1:0] {
        SCALE_TINY,
        SCALE_MID,
        SCALE_FULL,
        SCALE_EDGE
    } coord_scale_e;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // [31:0] coord_x, [63:32] coord_y
    logic [1:0]  s_tuser;    // [0] req_type, [1] first_vertex
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [0] inside_res, [1] vertices_dropped, rest zero

    int fail_count;
    int pending;
    int answers;
    int answers_inside;
    int answers_dropped;

    // idle odds in percent, changed per phase
    int src_idle_pct;
    int sink_idle_pct;

    // what the stimulus sent, for the summary
    int vertex_sent;
    int query_sent;
    int pass_sent;

    point_in_polygon_test_top #(
        .MAX_VERTICES (MAX_V)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ppt_checker #(
        .MAX_VERTICES (MAX_V)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .answers         (answers),
        .answers_inside  (answers_inside),
        .answers_dropped (answers_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side backpressure, redrawn every cycle, held low in reset
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        else
            m_tready <= 1'b0;
    end

    // watchdog: a hung block or lost result ends here
    initial
    begin
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d answers still expected", CYCLE_LIMIT, pending);
        $display("Mismatches found");
        $finish;
    end

    // one input transfer, with a random idle gap ahead of it
    task automatic send_item(ppt_req_e kind, logic first,
                             logic signed [31:0] x, logic signed [31:0] y);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {first, kind};
        s_tdata  <= {y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (kind == REQ_VERTEX)
            vertex_sent++;
        else
            query_sent++;
        pass_sent++;
    endtask

    // hold off the input until every query has answered
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_coord(coord_scale_e scale);
        case (scale)
            SCALE_TINY: return int'($urandom_range(16)) - 8;
            SCALE_MID:  return int'($urandom_range(2_000_000)) - 1_000_000;
            SCALE_FULL: return $urandom;
            default:
                case ($urandom_range(5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h8000_0001;
                    3:       return 32'h7fff_fffe;
                    4:       return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
        endcase
    endfunction

    function automatic coord_scale_e pick_scale();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return SCALE_TINY;
        if (r < 70)
            return SCALE_MID;
        if (r < 90)
            return SCALE_FULL;
        return SCALE_EDGE;
    endfunction

    // a fresh polygon, then a few queries aimed near it
    task automatic random_polygon(int forced_len);
        logic signed [31:0] xs [$];
        logic signed [31:0] ys [$];
        logic signed [31:0] qx, qy;
        coord_scale_e       scale;
        int                 len, queries, r, pick;
        scale = pick_scale();
        r = $urandom_range(99);
        if (forced_len > 0)
            len = forced_len;
        else if (r < 5)
            len = $urandom_range(2, 1);
        else if (r < 10)
            len = $urandom_range(MAX_V + 6, MAX_V - 2);
        else
            len = $urandom_range(12, 3);
        for (int k = 0; k < len; k++)
        begin
            xs.push_back(pick_coord(scale));
            ys.push_back(pick_coord(scale));
            send_item(REQ_VERTEX, (k == 0), xs[k], ys[k]);
        end
        queries = $urandom_range(6, 1);
        for (int q = 0; q < queries; q++)
        begin
            qx = pick_coord(scale);
            qy = pick_coord(scale);
            // land on vertex coordinates now and then to hit the tie rules
            pick = $urandom_range(len - 1);
            r = $urandom_range(99);
            if (r < 15)
                qy = ys[pick];
            else if (r < 25)
                qx = xs[pick];
            else if (r < 30)
            begin
                qx = xs[pick];
                qy = ys[pick];
            end
            // first_vertex on a query is ignored by the block
            send_item(REQ_QUERY, 1'($urandom_range(1)), qx, qy);
        end
    endtask

    // stray transfers: appends without a restart, lone queries
    task automatic noise_items();
        coord_scale_e scale;
        scale = pick_scale();
        if ($urandom_range(1))
            send_item(REQ_VERTEX, 1'b0, pick_coord(scale), pick_coord(scale));
        else
            send_item(REQ_QUERY, 1'($urandom_range(1)), pick_coord(scale),
                      pick_coord(scale));
    endtask

    task automatic directed_items();
        // empty polygon, with the ignored restart flag on the query
        send_item(REQ_QUERY, 1'b1, 32'sd0, 32'sd0);
        // one vertex, then two
        send_item(REQ_VERTEX, 1'b1, 32'sd0, 32'sd0);
        send_item(REQ_QUERY, 1'b0, 32'sd0, 32'sd0);
        send_item(REQ_VERTEX, 1'b0, 32'sd10, 32'sd10);
        send_item(REQ_QUERY, 1'b0, 32'sd5, 32'sd5);
        // square over the full coordinate range
        send_item(REQ_VERTEX, 1'b1, 32'h8000_0000, 32'h8000_0000);
        send_item(REQ_VERTEX, 1'b0, 32'h7fff_ffff, 32'h8000_0000);
        send_item(REQ_VERTEX, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(REQ_VERTEX, 1'b0, 32'h8000_0000, 32'h7fff_ffff);
        send_item(REQ_QUERY, 1'b0, 32'sd0, 32'sd0);
        send_item(REQ_QUERY, 1'b0, 32'h8000_0000, 32'sd0);
        send_item(REQ_QUERY, 1'b0, 32'h7fff_ffff, 32'sd0);
        send_item(REQ_QUERY, 1'b0, 32'sd0, 32'h7fff_ffff);
        send_item(REQ_QUERY, 1'b0, -32'sd1, -32'sd1);
        send_item(REQ_QUERY, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff);
        // small triangle with a horizontal edge, queries inside, outside and on its boundary
        send_item(REQ_VERTEX, 1'b1, 32'sd0, 32'sd0);
        send_item(REQ_VERTEX, 1'b0, 32'sd8, 32'sd0);
        send_item(REQ_VERTEX, 1'b0, 32'sd0, 32'sd8);
        send_item(REQ_QUERY, 1'b0, 32'sd1, 32'sd1);
        send_item(REQ_QUERY, 1'b0, 32'sd4, 32'sd4);
        send_item(REQ_QUERY, 1'b0, 32'sd0, 32'sd4);
        send_item(REQ_QUERY, 1'b0, 32'sd8, 32'sd0);
        send_item(REQ_QUERY, 1'b0, -32'sd1, 32'sd1);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        src_idle_pct  = 33;
        sink_idle_pct = 77;
        vertex_sent   = 0;
        query_sent    = 0;
        pass_sent     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_items();
        drain_answers();

        // three passes: slow receiver, slow sender, then full speed
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 33;
                    sink_idle_pct = 77;
                end
                1:
                begin
                    src_idle_pct  = 77;
                    sink_idle_pct = 33;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            pass_sent = 0;
            // start each pass by overrunning the store
            random_polygon(MAX_V + 3);
            while (pass_sent < ITEMS_PER_PASS)
            begin
                if ($urandom_range(99) < 10)
                    noise_items();
                else
                    random_polygon(0);
                if ($urandom_range(99) < 4)
                    drain_answers();
            end
            drain_answers();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d vertex and %0d query transfers over three idle patterns",
                 vertex_sent, query_sent);
        $display("checked %0d answers: %0d inside, %0d flagged with dropped vertices",
                 answers, answers_inside, answers_dropped);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
